@@ hdl/hsc_pkg.sv @@
// shared types and constants for the hamming(39,32) sec codec
package hsc_pkg;

    localparam int CW_W   = 39;
    localparam int DATA_W = 32;
    localparam int CHK_W  = 7;

    typedef logic [CW_W-1:0]   cw_t;
    typedef logic [DATA_W-1:0] data_t;
    typedef logic [CHK_W-1:0]  syn_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_CORRECTED = 2'd1,
        ST_UNCORR    = 2'd2
    } status_t;

    localparam logic CMD_ENCODE = 1'b0;
    localparam logic CMD_DECODE = 1'b1;

    // coverage of each check row over codeword bits 38..0
    localparam cw_t ROW_COVER [CHK_W] = '{
        39'h7F80007FC0,
        39'h7F807F8020,
        39'h607E607E10,
        39'h1C719C7188,
        39'h534CD34C84,
        39'h0AAB8AAB82,
        39'h5A1725E881
    };

endpackage

@@ hdl/hamming_39_32_sec_codec.sv @@
// hamming(39,32) single-error-correcting encoder and decoder, top level
//
// one input channel (in_valid, in_stall, cmd, word_in) and one output
// channel (out_valid, out_stall, word_out, syndrome, status); a transfer
// happens at a rising edge with valid high and stall low
// cmd selects encode (data in word_in[31:0]) or decode of a 39-bit codeword
// each input transfer yields exactly one output transfer, in order
// path: the input register, then parity trees, column compare and bit flip
// into the result register, which drives out_valid and the outputs
// throughput: one word per cycle while out_stall is low, set by the single
// parity/syndrome stage between the input register and the result register
// when the receiver stalls, the result register holds its word and the
// input register still takes one more word; in_stall rises only when both
// registers are full and out_stall is high
// reset (rst_n low, asynchronous) empties both registers; payload is not
// cleared
module hamming_39_32_sec_codec
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic             cmd,
    input  hsc_pkg::cw_t     word_in,
    output logic             out_valid,
    input  logic             out_stall,
    output hsc_pkg::cw_t     word_out,
    output hsc_pkg::syn_t    syndrome,
    output logic [1:0]       status
);
    import hsc_pkg::*;

    // input register stage
    logic    s1_valid_reg;
    logic    s1_valid_next;
    logic    s1_cmd_reg;
    cw_t     s1_word_reg;

    // result register stage
    logic    out_valid_reg;
    logic    out_valid_next;
    cw_t     word_out_reg;
    cw_t     word_out_next;
    syn_t    syndrome_reg;
    syn_t    syndrome_next;
    status_t status_reg;
    status_t status_next;

    logic    adv_out;
    logic    adv_s1;
    logic    in_take;

    // datapath
    cw_t     base_word;
    syn_t    par;
    cw_t     enc_word;
    cw_t     match;
    syn_t    col;

    // the result register moves when empty or being drained
    assign adv_out  = !out_valid_reg || !out_stall;
    // the input register moves when empty or its word goes on
    assign adv_s1   = !s1_valid_reg || adv_out;
    assign in_stall = !adv_s1;
    assign in_take  = in_valid && adv_s1;

    always_comb
    begin
        s1_valid_next  = s1_valid_reg;
        out_valid_next = out_valid_reg;
        if (adv_s1)
        begin
            s1_valid_next = in_valid;
        end
        if (adv_out)
        begin
            out_valid_next = s1_valid_reg;
        end
    end

    // encode places data above the check bits; decode takes the word as is
    always_comb
    begin
        if (s1_cmd_reg == CMD_ENCODE)
        begin
            base_word = {s1_word_reg[DATA_W-1:0], {CHK_W{1'b0}}};
        end
        else
        begin
            base_word = s1_word_reg;
        end
    end

    // one xor tree per check row: parity on encode, syndrome on decode
    // each row covers only its own check bit, so zeroed check bits give parity
    always_comb
    begin
        for (int i = 0; i < CHK_W; i++)
        begin
            par[i] = ^(base_word & ROW_COVER[i]);
        end
    end

    always_comb
    begin
        enc_word = base_word;
        for (int i = 0; i < CHK_W; i++)
        begin
            enc_word[CHK_W-1-i] = par[i];
        end
    end

    // compare the syndrome against every check-matrix column
    // columns are distinct and nonzero, so at most one bit matches
    always_comb
    begin
        col = '0;
        for (int b = 0; b < CW_W; b++)
        begin
            for (int i = 0; i < CHK_W; i++)
            begin
                col[i] = ROW_COVER[i][b];
            end
            match[b] = (par == col);
        end
    end

    always_comb
    begin
        if (s1_cmd_reg == CMD_ENCODE)
        begin
            word_out_next = enc_word;
            syndrome_next = '0;
            status_next   = ST_OK;
        end
        else
        begin
            word_out_next = s1_word_reg ^ match;
            syndrome_next = par;
            if (par == '0)
            begin
                status_next = ST_OK;
            end
            else if (|match)
            begin
                status_next = ST_CORRECTED;
            end
            else
            begin
                status_next = ST_UNCORR;
            end
        end
    end

    // control: valid bits only
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, loaded only when their stage moves
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_cmd_reg  <= cmd;
            s1_word_reg <= word_in;
        end
        if (adv_out && s1_valid_reg)
        begin
            word_out_reg <= word_out_next;
            syndrome_reg <= syndrome_next;
            status_reg   <= status_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign word_out  = word_out_reg;
    assign syndrome  = syndrome_reg;
    assign status    = status_reg;

    // a clean status goes with a zero syndrome and nothing else
    a_status_syn: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((status_reg == ST_OK) == (syndrome_reg == '0)))
        else $error("status and syndrome disagree");

    // only defined status codes leave the block
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status_reg == ST_OK || status_reg == ST_CORRECTED ||
                       status_reg == ST_UNCORR))
        else $error("undefined status code");

    // a stalled result is neither dropped nor replaced
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(word_out_reg) &&
                                   $stable(syndrome_reg))
        else $error("stalled result changed");

    // the input side only stalls when both stages are occupied
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> s1_valid_reg && out_valid_reg)
        else $error("input stalled with a free stage");

endmodule
